// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the blitter modules.
// Needs nothing else; every macro takes a clock, an active-low reset and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Antecedent in this cycle implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/ckbb_pkg.sv -----
// Shared types and constants of the colour-keyed bitmap blitter.
// Used by the controller, the datapath and the top level; depends on nothing.
package ckbb_pkg;

	localparam int BYTE_W     = 8;
	localparam int DIM_CFG_W  = 13;
	localparam int POS_W      = 12;
	localparam int BPP_W      = 3;
	localparam int COLOR_W    = 24;
	localparam int OFFSET_W   = 26;
	localparam int TDATA_W    = 56;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int PART_W     = 16;
	localparam int YPOS_W     = 13;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCREEN_WIDTH  = 3'd0,
		REG_SCREEN_HEIGHT = 3'd1,
		REG_BYTES_PER_PIX = 3'd2,
		REG_IMAGE_WIDTH   = 3'd3,
		REG_IMAGE_HEIGHT  = 3'd4,
		REG_DEST_X        = 3'd5,
		REG_DEST_Y        = 3'd6,
		REG_COLOR_KEY     = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_SCALE
	} ckbb_state_t;

	typedef struct packed {
		logic take;
		logic mul;
		logic load;
	} ckbb_cmd_t;

	typedef struct packed {
		logic pix_done;
		logic out_free;
	} ckbb_sts_t;

endpackage

// ----- rtl/ckbb_ctrl.sv -----
// Controller of the blitter: sequences byte intake, the row multiply and the offset scaling.
// Depends on ckbb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ckbb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  ckbb_pkg::ckbb_sts_t sts,
	output ckbb_pkg::ckbb_cmd_t cmd
);
	import ckbb_pkg::*;

	ckbb_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.take = s_tvalid;
				if (s_tvalid && sts.pix_done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.load = sts.out_free;
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`ASSERT_NEXT(a_pix_to_mul, clk, arst_n, cmd.take && sts.pix_done, state_q == ST_MUL,
		"completed pixel did not start the multiply")
	`ASSERT_NEXT(a_scale_holds, clk, arst_n, state_q == ST_SCALE && !sts.out_free,
		state_q == ST_SCALE && !s_tready, "result left scaling while the output was full")

endmodule

// ----- rtl/ckbb_dp.sv -----
// Blitter datapath: configuration registers, pixel assembly, row and column counters,
// clipping, offset arithmetic and output register. Uses ckbb_pkg, assert_macros.svh.
`include "assert_macros.svh"

module ckbb_dp #(
	parameter int MAX_DIM = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [ckbb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ckbb_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [ckbb_pkg::BYTE_W-1:0]         src_byte,
	input  ckbb_pkg::ckbb_cmd_t                 cmd,
	output ckbb_pkg::ckbb_sts_t                 sts,
	input  logic                                m_tready,
	output logic                                m_tvalid,
	output logic [ckbb_pkg::OFFSET_W-1:0]       fb_offset,
	output logic [ckbb_pkg::COLOR_W-1:0]        pixel_color,
	output logic                                write_enable,
	output logic                                last_pixel
);
	import ckbb_pkg::*;

	localparam int CW  = $clog2(MAX_DIM);
	localparam int DW  = $clog2(MAX_DIM + 1);
	localparam int ZW  = (DW > DIM_CFG_W) ? DW : DIM_CFG_W;
	localparam int XW  = ((CW > POS_W) ? CW : POS_W) + 1;
	localparam int KW  = (XW > DIM_CFG_W) ? XW : DIM_CFG_W;
	localparam int YW  = ((DW > POS_W) ? DW : POS_W) + 2;
	localparam int YKW = ((YW - 1) > DIM_CFG_W) ? (YW - 1) : DIM_CFG_W;
	localparam int MW  = OFFSET_W + BPP_W;

	logic [DIM_CFG_W-1:0] screen_width_q, screen_height_q, image_width_q, image_height_q;
	logic [BPP_W-1:0]     bpp_q;
	logic [POS_W-1:0]     dest_x_q, dest_y_q;
	logic [COLOR_W-1:0]   color_key_q;

	logic [1:0]        phase_q, pad_q;
	logic [PART_W-1:0] part_q;
	logic [CW-1:0]     col_q, row_q;

	logic [COLOR_W-1:0]  color_s1;
	logic [XW-1:0]       colpos_s1;
	logic [YPOS_W-1:0]   ypos_s1;
	logic                we_s1, last_s1;
	logic [OFFSET_W-1:0] prod_s2;

	logic                m_tvalid_q;
	logic [OFFSET_W-1:0] offset_q;
	logic [COLOR_W-1:0]  color_q;
	logic                we_q, last_q;

	logic [DW-1:0]       w_c, h_c, col_inc, row_inc;
	logic                row_end, row_wrap;
	logic [COLOR_W-1:0]  color_c;
	logic [XW-1:0]       colpos_c;
	logic [YW-1:0]       ypos_c;
	logic                col_ok, y_ok, we_c;
	logic [OFFSET_W-1:0] sum_c;
	logic [MW-1:0]       scaled_c;

	always_comb begin
		if (image_width_q == '0) begin
			w_c = DW'(1);
		end else if (ZW'(image_width_q) > ZW'(MAX_DIM)) begin
			w_c = DW'(MAX_DIM);
		end else begin
			w_c = DW'(image_width_q);
		end
		if (image_height_q == '0) begin
			h_c = DW'(1);
		end else if (ZW'(image_height_q) > ZW'(MAX_DIM)) begin
			h_c = DW'(MAX_DIM);
		end else begin
			h_c = DW'(image_height_q);
		end
		col_inc  = DW'(col_q) + DW'(1);
		row_inc  = DW'(row_q) + DW'(1);
		row_end  = col_inc >= w_c;
		row_wrap = row_inc >= h_c;
		color_c  = {src_byte, part_q};
		colpos_c = XW'(dest_x_q) + XW'(col_q);
		ypos_c   = YW'(dest_y_q) + YW'(h_c) - YW'(1) - YW'(row_q);
		col_ok   = KW'(colpos_c) < KW'(screen_width_q);
		y_ok     = !ypos_c[YW-1] && (YKW'(ypos_c[YW-2:0]) < YKW'(screen_height_q));
		we_c     = (color_c != color_key_q) && col_ok && y_ok;
		sum_c    = prod_s2 + OFFSET_W'(colpos_s1);
		scaled_c = MW'(sum_c) * MW'(bpp_q);
	end

	assign sts.pix_done = (pad_q == 2'd0) && (phase_q == 2'd2);
	assign sts.out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= DIM_CFG_W'(640);
			screen_height_q <= DIM_CFG_W'(480);
			bpp_q           <= BPP_W'(4);
			image_width_q   <= DIM_CFG_W'(1);
			image_height_q  <= DIM_CFG_W'(1);
			dest_x_q        <= '0;
			dest_y_q        <= '0;
			color_key_q     <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data[DIM_CFG_W-1:0];
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data[DIM_CFG_W-1:0];
				REG_BYTES_PER_PIX: bpp_q           <= cfg_data[BPP_W-1:0];
				REG_IMAGE_WIDTH:   image_width_q   <= cfg_data[DIM_CFG_W-1:0];
				REG_IMAGE_HEIGHT:  image_height_q  <= cfg_data[DIM_CFG_W-1:0];
				REG_DEST_X:        dest_x_q        <= cfg_data[POS_W-1:0];
				REG_DEST_Y:        dest_y_q        <= cfg_data[POS_W-1:0];
				REG_COLOR_KEY:     color_key_q     <= cfg_data[COLOR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			pad_q   <= '0;
			part_q  <= '0;
			col_q   <= '0;
			row_q   <= '0;
		end else if (cmd.take) begin
			if (pad_q != 2'd0) begin
				pad_q <= pad_q - 2'd1;
				if (pad_q == 2'd1) begin
					col_q <= '0;
					row_q <= row_wrap ? '0 : row_inc[CW-1:0];
				end
			end else if (phase_q != 2'd2) begin
				part_q  <= part_q | (phase_q == 2'd0 ? {8'h00, src_byte} : {src_byte, 8'h00});
				phase_q <= phase_q + 2'd1;
			end else begin
				phase_q <= '0;
				part_q  <= '0;
				if (row_end) begin
					pad_q <= w_c[1:0];
					if (w_c[1:0] == 2'd0) begin
						col_q <= '0;
						row_q <= row_wrap ? '0 : row_inc[CW-1:0];
					end
				end else begin
					col_q <= col_inc[CW-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && sts.pix_done) begin
			color_s1  <= color_c;
			colpos_s1 <= colpos_c;
			ypos_s1   <= ypos_c[YPOS_W-1:0];
			we_s1     <= we_c;
			last_s1   <= row_end && row_wrap;
		end
		if (cmd.mul) begin
			prod_s2 <= OFFSET_W'(ypos_s1) * OFFSET_W'(screen_width_q);
		end
		if (cmd.load) begin
			offset_q <= we_s1 ? scaled_c[OFFSET_W-1:0] : '0;
			color_q  <= color_s1;
			we_q     <= we_s1;
			last_q   <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid     = m_tvalid_q;
	assign fb_offset    = offset_q;
	assign pixel_color  = color_q;
	assign write_enable = we_q;
	assign last_pixel   = last_q;

	`ASSERT_CLK(a_clip_zero_offset, clk, arst_n, !m_tvalid_q || we_q || offset_q == '0,
		"suppressed pixel carries a non-zero offset")
	`ASSERT_CLK(a_pad_at_pixel_edge, clk, arst_n, pad_q == 2'd0 || phase_q == 2'd0,
		"row padding pending inside a pixel")

endmodule

// ----- rtl/color_key_bitmap_blit.sv -----
// Colour-keyed 24-bit bitmap blitter, top level.
// Usage: bitmap pixel bytes enter on the s_ stream, one byte per item in s_tdata.
// Every third non-padding byte completes a pixel and yields one item on the m_ stream:
// m_tdata holds the frame-buffer byte offset and the colour, m_tuser the write enable,
// m_tlast marks the final pixel of the bitmap. Padding bytes yield nothing.
// Padding and the first two bytes of a pixel are taken one per cycle. After the third
// byte the intake pauses while the controller passes ST_MUL, where the row offset is
// multiplied by the screen width, and then ST_SCALE, where the offset is scaled by the
// bytes per pixel and loaded into the output register once that register is free.
// The result sits in an output register; while the receiver stalls the next pixel's
// bytes are still taken, and the block waits only when a second result is ready.
// The configuration channel writes one register per item, index in cfg_index; the user
// must write only while no pixel is in flight (not enforced). Reset loads the default
// registers (640 by 480 screen, four bytes per pixel, a one by one image at the origin,
// black key) and clears the byte, column, row and padding counters and the output valid.
// Depends on ckbb_pkg, ckbb_ctrl and ckbb_dp.

module color_key_bitmap_blit #(
	parameter int MAX_DIM = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ckbb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ckbb_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [ckbb_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] src_byte
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [ckbb_pkg::TDATA_W-1:0]     m_tdata,   // [25:0] fb_offset, [49:26] pixel_color
	output logic                             m_tuser,   // [0] write_enable
	output logic                             m_tlast
);
	import ckbb_pkg::*;

	ckbb_cmd_t           cmd;
	ckbb_sts_t           sts;
	logic [OFFSET_W-1:0] fb_offset;
	logic [COLOR_W-1:0]  pixel_color;

	assign cfg_ready = 1'b1;

	ckbb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ckbb_dp #(
		.MAX_DIM (MAX_DIM)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.src_byte     (s_tdata),
		.cmd          (cmd),
		.sts          (sts),
		.m_tready     (m_tready),
		.m_tvalid     (m_tvalid),
		.fb_offset    (fb_offset),
		.pixel_color  (pixel_color),
		.write_enable (m_tuser),
		.last_pixel   (m_tlast)
	);

	assign m_tdata = {{(TDATA_W - OFFSET_W - COLOR_W){1'b0}}, pixel_color, fb_offset};

endmodule
